[src/tcfm_pkg.sv]
// shared types and constants for the three-class fifo manager
// request and result payload structs, request, queue and status codes
// no dependencies

package tcfm_pkg;

    localparam int REQ_TYPE_W   = 2;
    localparam int QSEL_W       = 2;
    localparam int ID_FIELD_W   = 16;
    localparam int STATUS_W     = 2;
    localparam int ITEM_COUNT_W = 5;
    localparam int NUM_QUEUES   = 3;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP  = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_MOVE = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_PEEK = 2'd3;

    // queue selector codes
    localparam logic [QSEL_W-1:0] QSEL_READY    = 2'd0;
    localparam logic [QSEL_W-1:0] QSEL_DEVICE   = 2'd1;
    localparam logic [QSEL_W-1:0] QSEL_FINISHED = 2'd2;
    localparam logic [QSEL_W-1:0] QSEL_NONE     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [QSEL_W-1:0]     queue_sel;
        logic [QSEL_W-1:0]     dest_queue;
        logic [ID_FIELD_W-1:0] proc_id;
    } tcfm_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [ID_FIELD_W-1:0]   item_id;
        logic [ITEM_COUNT_W-1:0] item_count;
    } tcfm_rsp_t;

endpackage

[src/tcfm_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; contents are undefined until written

module tcfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[src/three_class_fifo_manager_unit.sv]
// top level of the three-class fifo manager: queue pointers, request sequencer, result register
// depends on tcfm_pkg and tcfm_ram

// Keeps three fifo queues of process identifiers (ready, device wait, finished) in one
// shared ram of 3*QUEUE_DEPTH entries, with head, tail and fill count per queue in flops.
// Each request pushes, pops, peeks or moves the head of one queue to the tail of another,
// and yields exactly one result with a status, the identifier involved and a fill count.
// In the accept cycle the head entry of the source queue is read from the ram, and in the
// update cycle the result is formed, the pointers are updated and a push or move writes the
// destination tail. The sequencer then returns to accepting; no new request is taken until
// the last one has finished its update cycle. The result sits in an output register, so a
// new request is accepted while an earlier result still waits; the update cycle stalls only
// when that register is still occupied. Selector value three names no queue: as a source
// it reads as empty, as a destination it reads as full.
// The ram has no reset; a value read from it is used only when the source queue is not empty.

module three_class_fifo_manager_unit
    import tcfm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  tcfm_req_t s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output tcfm_rsp_t m_payload
);

    localparam int IDX_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    // sequencer states
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    // ram base of a queue plus slot index
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [QSEL_W-1:0] q,
                                                    input logic [IDX_W-1:0]  idx);
        logic [ADDR_W-1:0] base;
        case (q)
            QSEL_DEVICE:   base = ADDR_W'(QUEUE_DEPTH);
            QSEL_FINISHED: base = ADDR_W'(2 * QUEUE_DEPTH);
            default:       base = '0;
        endcase
        return base + ADDR_W'(idx);
    endfunction

    // circular increment of a slot index
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // sequencer and captured request
    logic      state_reg, state_next;
    tcfm_req_t req_reg;

    // per-queue pointers and counts
    logic [IDX_W-1:0] head_reg  [NUM_QUEUES];
    logic [IDX_W-1:0] head_next [NUM_QUEUES];
    logic [IDX_W-1:0] tail_reg  [NUM_QUEUES];
    logic [IDX_W-1:0] tail_next [NUM_QUEUES];
    logic [CNT_W-1:0] count_reg [NUM_QUEUES];
    logic [CNT_W-1:0] count_next[NUM_QUEUES];

    // result register
    logic      m_valid_reg, m_valid_next;
    tcfm_rsp_t m_payload_reg;

    // ram signals
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ID_WIDTH-1:0] mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [ID_WIDTH-1:0] mem_rdata;

    // request decode in the update cycle
    logic [QSEL_W-1:0]   src_q, dst_q, in_q;
    logic                src_ok, dst_ok;
    logic [ID_WIDTH-1:0] push_id;
    logic [ID_WIDTH+ID_FIELD_W-1:0] push_ext;
    logic                commit;

    // result fields before width fitting
    logic [STATUS_W-1:0]            rsp_status;
    logic [ID_WIDTH-1:0]            rsp_id;
    logic [CNT_W-1:0]               rsp_count;
    logic [ID_WIDTH+ID_FIELD_W-1:0] rsp_id_ext;
    logic [CNT_W+ITEM_COUNT_W-1:0]  rsp_count_ext;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // update cycle may finish once the result register is free
    assign commit = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    // head read of the source queue in the accept cycle
    assign in_q      = (s_payload.queue_sel == QSEL_NONE) ? QSEL_READY : s_payload.queue_sel;
    assign mem_re    = s_valid && s_ready;
    assign mem_raddr = slot_addr(in_q, head_reg[in_q]);

    // identifier kept to ID_WIDTH bits, zero-extended if wider than the field
    assign push_ext = {{ID_WIDTH{1'b0}}, req_reg.proc_id};
    assign push_id  = push_ext[ID_WIDTH-1:0];

    assign src_ok = (req_reg.queue_sel != QSEL_NONE);
    assign dst_ok = (req_reg.dest_queue != QSEL_NONE);
    assign src_q  = src_ok ? req_reg.queue_sel : QSEL_READY;
    assign dst_q  = dst_ok ? req_reg.dest_queue : QSEL_READY;

    tcfm_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request execution: pointer update, ram write and result
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = slot_addr(src_q, tail_reg[src_q]);
        mem_wdata  = push_id;
        rsp_status = STAT_DONE;
        rsp_id     = '0;
        rsp_count  = '0;

        if (req_reg.req_type == REQ_PUSH) begin
            if (!src_ok) begin
                rsp_status = STAT_FULL;
            end else if (count_reg[src_q] == FULL_CNT) begin
                rsp_status = STAT_FULL;
                rsp_count  = count_reg[src_q];
            end else begin
                mem_we            = commit;
                tail_next[src_q]  = next_idx(tail_reg[src_q]);
                count_next[src_q] = count_reg[src_q] + 1'b1;
                rsp_id            = push_id;
                rsp_count         = count_next[src_q];
            end
        end else if (!src_ok || count_reg[src_q] == '0) begin
            // empty or missing source queue
            rsp_status = STAT_EMPTY;
        end else if (req_reg.req_type == REQ_PEEK) begin
            rsp_id    = mem_rdata;
            rsp_count = count_reg[src_q];
        end else if (req_reg.req_type == REQ_POP) begin
            head_next[src_q]  = next_idx(head_reg[src_q]);
            count_next[src_q] = count_reg[src_q] - 1'b1;
            if (count_next[src_q] == '0) begin
                head_next[src_q] = '0;
                tail_next[src_q] = '0;
            end
            rsp_id    = mem_rdata;
            rsp_count = count_next[src_q];
        end else begin
            // move: destination checks, then take head and append
            if (!dst_ok) begin
                rsp_status = STAT_FULL;
            end else if (dst_q != src_q && count_reg[dst_q] == FULL_CNT) begin
                rsp_status = STAT_FULL;
                rsp_count  = count_reg[dst_q];
            end else begin
                head_next[src_q]  = next_idx(head_reg[src_q]);
                count_next[src_q] = count_reg[src_q] - 1'b1;
                if (count_next[src_q] == '0) begin
                    head_next[src_q] = '0;
                    tail_next[src_q] = '0;
                end
                mem_we            = commit;
                mem_waddr         = slot_addr(dst_q, tail_next[dst_q]);
                mem_wdata         = mem_rdata;
                tail_next[dst_q]  = next_idx(tail_next[dst_q]);
                count_next[dst_q] = count_next[dst_q] + 1'b1;
                rsp_id            = mem_rdata;
                rsp_count         = count_next[dst_q];
            end
        end
    end

    // fit result to the port field widths
    assign rsp_id_ext    = {{ID_FIELD_W{1'b0}}, rsp_id};
    assign rsp_count_ext = {{ITEM_COUNT_W{1'b0}}, rsp_count};

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (commit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                head_reg[q]  <= '0;
                tail_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_payload;
        end
        if (commit) begin
            m_payload_reg.status     <= rsp_status;
            m_payload_reg.item_id    <= rsp_id_ext[ID_FIELD_W-1:0];
            m_payload_reg.item_count <= rsp_count_ext[ITEM_COUNT_W-1:0];
        end
    end

    // no second request while one is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // fill counts never exceed the queue depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg[0] <= FULL_CNT) && (count_reg[1] <= FULL_CNT)
        && (count_reg[2] <= FULL_CNT))
        else $error("fill count above queue depth");

    // an empty queue has both pointers at zero
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        ((count_reg[0] != '0) || (head_reg[0] == '0 && tail_reg[0] == '0))
        && ((count_reg[1] != '0) || (head_reg[1] == '0 && tail_reg[1] == '0))
        && ((count_reg[2] != '0) || (head_reg[2] == '0 && tail_reg[2] == '0)))
        else $error("empty queue with nonzero pointers");

    // a failed request reports identifier zero
    a_fail_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.status != STAT_DONE) |-> (m_payload.item_id == '0))
        else $error("failed request with nonzero identifier");

    // pointers and fill counts only move in an update cycle; the check covers the fill counts
    a_ptr_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> ($stable(count_reg[0]) && $stable(count_reg[1])
        && $stable(count_reg[2])))
        else $error("fill count changed outside an update cycle");

endmodule

[sim/tcfm_queue_checker.sv]
// request/result checker for the three-class fifo manager: watches both channels,
// predicts each result from its own copy of the three queues and compares field by field
// depends on tcfm_pkg

module tcfm_queue_checker
    import tcfm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  tcfm_req_t s_payload,
    input  logic      m_valid,
    input  logic      m_ready,
    input  tcfm_rsp_t m_payload,
    output int        fail_count,
    output int        owed_count,
    output int        checked_count,
    output int        empty_count,
    output int        full_count
);

    // shadow copy of the three circular queues
    logic [ID_WIDTH-1:0] id_slot [NUM_QUEUES*QUEUE_DEPTH];
    int head_at [NUM_QUEUES] = '{default: 0};
    int tail_at [NUM_QUEUES] = '{default: 0};
    int fill_of [NUM_QUEUES] = '{default: 0};

    tcfm_rsp_t owed_rsp [$];

    int n_fail    = 0;
    int n_owed    = 0;
    int n_checked = 0;
    int n_empty   = 0;
    int n_full    = 0;

    assign fail_count    = n_fail;
    assign owed_count    = n_owed;
    assign checked_count = n_checked;
    assign empty_count   = n_empty;
    assign full_count    = n_full;

    function automatic void append_id(int q, logic [ID_WIDTH-1:0] id);
        id_slot[q*QUEUE_DEPTH + tail_at[q]] = id;
        tail_at[q] = (tail_at[q] + 1) % QUEUE_DEPTH;
        fill_of[q]++;
    endfunction

    function automatic logic [ID_WIDTH-1:0] take_head(int q);
        logic [ID_WIDTH-1:0] id;
        id = id_slot[q*QUEUE_DEPTH + head_at[q]];
        head_at[q] = (head_at[q] + 1) % QUEUE_DEPTH;
        fill_of[q]--;
        if (fill_of[q] == 0) begin
            head_at[q] = 0;
            tail_at[q] = 0;
        end
        return id;
    endfunction

    // applies one request to the shadow queues and returns the result it owes
    function automatic tcfm_rsp_t apply_request(tcfm_req_t r);
        tcfm_rsp_t rsp;
        int src;
        int dst;
        logic [ID_WIDTH-1:0] id;
        rsp = '0;
        rsp.status = STAT_DONE;
        src = int'(r.queue_sel);
        dst = int'(r.dest_queue);
        if (r.req_type == REQ_PUSH) begin
            if (src >= NUM_QUEUES) begin
                rsp.status = STAT_FULL;
            end else if (fill_of[src] >= QUEUE_DEPTH) begin
                rsp.status     = STAT_FULL;
                rsp.item_count = ITEM_COUNT_W'(fill_of[src]);
            end else begin
                id = r.proc_id[ID_WIDTH-1:0];
                append_id(src, id);
                rsp.item_id    = ID_FIELD_W'(id);
                rsp.item_count = ITEM_COUNT_W'(fill_of[src]);
            end
        end else if (src >= NUM_QUEUES || fill_of[src] == 0) begin
            rsp.status = STAT_EMPTY;
        end else if (r.req_type == REQ_POP) begin
            rsp.item_id    = ID_FIELD_W'(take_head(src));
            rsp.item_count = ITEM_COUNT_W'(fill_of[src]);
        end else if (r.req_type == REQ_PEEK) begin
            rsp.item_id    = ID_FIELD_W'(id_slot[src*QUEUE_DEPTH + head_at[src]]);
            rsp.item_count = ITEM_COUNT_W'(fill_of[src]);
        end else if (dst >= NUM_QUEUES) begin
            rsp.status = STAT_FULL;
        end else if (dst != src && fill_of[dst] >= QUEUE_DEPTH) begin
            rsp.status     = STAT_FULL;
            rsp.item_count = ITEM_COUNT_W'(fill_of[dst]);
        end else begin
            // head leaves first, so a rotate within a full queue still fits
            id = take_head(src);
            append_id(dst, id);
            rsp.item_id    = ID_FIELD_W'(id);
            rsp.item_count = ITEM_COUNT_W'(fill_of[dst]);
        end
        return rsp;
    endfunction

    task automatic note_failure(string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge aclk) begin : watch
        tcfm_rsp_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                owed_rsp.push_back(apply_request(s_payload));
            end
            if (m_valid && m_ready) begin
                if (owed_rsp.size() == 0) begin
                    note_failure($sformatf("result with none owed: status %0d id %0h count %0d",
                        m_payload.status, m_payload.item_id, m_payload.item_count));
                end else begin
                    want = owed_rsp.pop_front();
                    n_checked++;
                    if (want.status == STAT_EMPTY) n_empty++;
                    if (want.status == STAT_FULL) n_full++;
                    if (m_payload.status !== want.status)
                        note_failure($sformatf("status expected %0d got %0d",
                            want.status, m_payload.status));
                    if (m_payload.item_id !== want.item_id)
                        note_failure($sformatf("item_id expected %0h got %0h",
                            want.item_id, m_payload.item_id));
                    if (m_payload.item_count !== want.item_count)
                        note_failure($sformatf("item_count expected %0d got %0d",
                            want.item_count, m_payload.item_count));
                end
            end
            // results still owed after this edge
            n_owed = owed_rsp.size();
        end
    end

endmodule

[sim/tb_three_class_fifo_manager_unit.sv]
// testbench top for the three-class fifo manager: clock, reset, request stimulus,
// result back-pressure and the verdict
// depends on tcfm_pkg, three_class_fifo_manager_unit and tcfm_queue_checker

module tb_three_class_fifo_manager_unit;
    import tcfm_pkg::*;

    localparam int QDEPTH         = 16;
    localparam int IDW            = 16;
    localparam int ITEMS_PER_PASS = 120;
    localparam int BURST_LEN      = 40;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tcfm_req_t s_payload;
    logic      m_valid;
    logic      m_ready;
    tcfm_rsp_t m_payload;

    // idle and stall odds in percent, changed per pass
    int idle_pct  = 0;
    int stall_pct = 0;
    int n_sent    = 0;

    int fail_count;
    int owed_count;
    int checked_count;
    int empty_count;
    int full_count;

    three_class_fifo_manager_unit #(
        .QUEUE_DEPTH(QDEPTH),
        .ID_WIDTH   (IDW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    tcfm_queue_checker #(
        .QUEUE_DEPTH(QDEPTH),
        .ID_WIDTH   (IDW)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_payload    (m_payload),
        .fail_count   (fail_count),
        .owed_count   (owed_count),
        .checked_count(checked_count),
        .empty_count  (empty_count),
        .full_count   (full_count)
    );

    // 10 unit period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result side back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard limit on the run, far above the slowest legal run
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // sends one request; called at a falling edge, returns at a falling edge.
    // idle cycles come first, then valid is held with a fixed payload until accepted
    task automatic issue(input logic [REQ_TYPE_W-1:0] kind, input logic [QSEL_W-1:0] qsel,
                         input logic [QSEL_W-1:0] dst, input logic [ID_FIELD_W-1:0] pid);
        tcfm_req_t r;
        r.req_type   = kind;
        r.queue_sel  = qsel;
        r.dest_queue = dst;
        r.proc_id    = pid;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        @(negedge aclk);
    endtask

    // holds the sender back until every owed result has come out
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (owed_count != 0) @(negedge aclk);
    endtask

    initial begin : stimulus
        logic [REQ_TYPE_W-1:0] kind;
        logic [QSEL_W-1:0]     qsel;
        logic [QSEL_W-1:0]     dst;
        logic [QSEL_W-1:0]     favored;
        logic [ID_FIELD_W-1:0] pid;
        int                    push_bias;

        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        m_ready   = 1'b0;
        favored   = QSEL_READY;
        push_bias = 50;

        // synchronous reset held low from time zero, released at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed part, no idling on either side ----
        // sources that hold nothing: unnamed selector, then an empty queue
        issue(REQ_POP, QSEL_NONE, QSEL_READY, 16'h1234);
        issue(REQ_MOVE, QSEL_DEVICE, QSEL_READY, 16'h0000);
        // push to the unnamed selector reads as full
        issue(REQ_PUSH, QSEL_NONE, QSEL_READY, 16'hFFFF);
        // fill the finished queue to the brim, extreme ids first
        for (int i = 0; i < QDEPTH; i++) begin
            pid = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : 16'($urandom);
            issue(REQ_PUSH, QSEL_FINISHED, QSEL_READY, pid);
        end
        // push into a full queue
        issue(REQ_PUSH, QSEL_FINISHED, QSEL_READY, 16'hABCD);
        // rotate within a full queue always succeeds
        issue(REQ_MOVE, QSEL_FINISHED, QSEL_FINISHED, 16'h0000);
        issue(REQ_PEEK, QSEL_FINISHED, QSEL_READY, 16'h0000);
        // move to the unnamed selector reads as full
        issue(REQ_MOVE, QSEL_FINISHED, QSEL_NONE, 16'h0000);
        // one entry over to the ready queue, then refill finished
        issue(REQ_MOVE, QSEL_FINISHED, QSEL_READY, 16'h0000);
        issue(REQ_PUSH, QSEL_FINISHED, QSEL_READY, 16'h5A5A);
        // move into a different full queue
        issue(REQ_MOVE, QSEL_READY, QSEL_FINISHED, 16'h0000);
        // ready queue empties here, which clears its pointers
        issue(REQ_POP, QSEL_READY, QSEL_READY, 16'h0000);
        issue(REQ_PEEK, QSEL_READY, QSEL_READY, 16'h0000);
        // refill after emptying starts from slot zero again
        issue(REQ_PUSH, QSEL_READY, QSEL_READY, 16'h8001);
        issue(REQ_PEEK, QSEL_READY, QSEL_DEVICE, 16'h0000);

        // sender waits for the block to go fully quiet once
        drain();

        // ---- random part in four idling passes ----
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            for (int k = 0; k < ITEMS_PER_PASS; k++) begin
                // each burst leans toward filling or emptying one favored queue,
                // so full and empty conditions come up often
                if (k % BURST_LEN == 0) begin
                    favored = QSEL_W'($urandom_range(2));
                    case ($urandom_range(2))
                        0: push_bias = 12;
                        1: push_bias = 50;
                        default: push_bias = 88;
                    endcase
                end
                if ($urandom_range(99) < push_bias) begin
                    kind = REQ_PUSH;
                end else begin
                    case ($urandom_range(2))
                        0: kind = REQ_POP;
                        1: kind = REQ_MOVE;
                        default: kind = REQ_PEEK;
                    endcase
                end
                // mostly the favored queue, sometimes any selector including none
                qsel = ($urandom_range(99) < 65) ? favored : QSEL_W'($urandom_range(3));
                dst  = ($urandom_range(99) < 8) ? QSEL_NONE : QSEL_W'($urandom_range(2));
                case ($urandom_range(19))
                    0: pid = 16'h0000;
                    1: pid = 16'hFFFF;
                    default: pid = 16'($urandom);
                endcase
                issue(kind, qsel, dst, pid);
            end
        end

        // wind down: nothing owed, then quiet cycles for stray results
        drain();
        repeat (10) @(negedge aclk);

        $display("%0d requests sent, %0d results checked", n_sent, checked_count);
        $display("%0d empty-source and %0d full-destination results among them",
                 empty_count, full_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
